// ===== rtl/bsa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared types, codes and constants of the bitmap slot allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

    localparam int MAX_SLOTS_DEF    = 256;
    localparam int MAP_ROWS_DEF     = 4;

    localparam int WORD_BITS  = 64;
    localparam int BIT_W      = 6;
    localparam int ADDR_W     = 32;
    localparam int SIZE_W     = 32;
    localparam int SB_W       = 17;
    localparam int SIU_W      = 9;
    localparam int SIDX_W     = 8;
    localparam int REQ_W      = 2;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 64;
    localparam int DIV_STEPS  = 32;
    localparam int DIV_CNT_W  = 6;

    localparam logic [ADDR_W-1:0] SLOT_BASE_RST    = 32'd4096;
    localparam logic [SB_W-1:0]   SLOT_BYTES_RST   = 17'd64;
    localparam logic [SIU_W-1:0]  SLOTS_IN_USE_RST = 9'd256;

    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC,
        REQ_FREE,
        REQ_RESIZE,
        REQ_REMAP
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_BAD_SIZE,
        ST_FULL,
        ST_FOREIGN,
        ST_MISALIGNED,
        ST_DOUBLE_FREE
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SLOT_BASE,
        REG_SLOT_BYTES,
        REG_SLOTS_IN_USE
    } t_reg_idx;

    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_FREE,
        OP_RESIZE
    } t_op;

    typedef enum logic [1:0] {
        RK_CODE,
        RK_RESIZE,
        RK_ALLOC,
        RK_FREE
    } t_res_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_ALLOC_RD,
        S_ALLOC_CHK,
        S_ALLOC_ADD,
        S_FREE_RANGE,
        S_FREE_DIV,
        S_FREE_ALIGN,
        S_FREE_CHK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic      load;
        logic      rd_issue;
        logic      rd_free;
        logic      word_inc;
        logic      mul_region;
        logic      mul_idx;
        logic      alloc_wr;
        logic      free_wr;
        logic      div_start;
        logic      div_step;
        logic      res_we;
        t_res_kind res_kind;
        t_status   res_code;
        logic      out_load;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic size_bad;
        logic addr_null;
        logic foreign;
        logic hit;
        logic scan_last;
        logic div_done;
        logic misaligned;
        logic bit_set;
        logic out_free;
    } t_stat;

endpackage

// ===== rtl/bsa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_ctrl
// Sequencer of the slot allocator: steps each request through decode and,
// as its kind needs, bitmap scan, offset check, division and bitmap update.
// ----------------------------------------------------------------------------
module bsa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  bsa_pkg::t_stat i_stat,
    output bsa_pkg::t_cmd  o_cmd
);

    bsa_pkg::t_state r_state;
    bsa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bsa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            bsa_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = bsa_pkg::S_DECIDE;
                end
            end
            bsa_pkg::S_DECIDE: begin
                unique case (i_stat.op)
                    bsa_pkg::OP_RESIZE: begin
                        o_cmd.res_we   = 1'b1;
                        o_cmd.res_kind = bsa_pkg::RK_RESIZE;
                        n_state        = bsa_pkg::S_DONE;
                    end
                    bsa_pkg::OP_ALLOC: begin
                        if (i_stat.size_bad) begin
                            o_cmd.res_we   = 1'b1;
                            o_cmd.res_kind = bsa_pkg::RK_CODE;
                            o_cmd.res_code = bsa_pkg::ST_BAD_SIZE;
                            n_state        = bsa_pkg::S_DONE;
                        end else begin
                            o_cmd.rd_issue = 1'b1;
                            n_state        = bsa_pkg::S_ALLOC_CHK;
                        end
                    end
                    bsa_pkg::OP_FREE: begin
                        if (i_stat.addr_null) begin
                            o_cmd.res_we   = 1'b1;
                            o_cmd.res_kind = bsa_pkg::RK_CODE;
                            o_cmd.res_code = bsa_pkg::ST_OK;
                            n_state        = bsa_pkg::S_DONE;
                        end else begin
                            o_cmd.mul_region = 1'b1;
                            n_state          = bsa_pkg::S_FREE_RANGE;
                        end
                    end
                    default: begin
                        n_state = bsa_pkg::S_IDLE;
                    end
                endcase
            end
            bsa_pkg::S_ALLOC_RD: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = bsa_pkg::S_ALLOC_CHK;
            end
            bsa_pkg::S_ALLOC_CHK: begin
                if (i_stat.hit) begin
                    o_cmd.alloc_wr = 1'b1;
                    o_cmd.mul_idx  = 1'b1;
                    n_state        = bsa_pkg::S_ALLOC_ADD;
                end else if (i_stat.scan_last) begin
                    o_cmd.res_we   = 1'b1;
                    o_cmd.res_kind = bsa_pkg::RK_CODE;
                    o_cmd.res_code = bsa_pkg::ST_FULL;
                    n_state        = bsa_pkg::S_DONE;
                end else begin
                    o_cmd.word_inc = 1'b1;
                    n_state        = bsa_pkg::S_ALLOC_RD;
                end
            end
            bsa_pkg::S_ALLOC_ADD: begin
                o_cmd.res_we   = 1'b1;
                o_cmd.res_kind = bsa_pkg::RK_ALLOC;
                n_state        = bsa_pkg::S_DONE;
            end
            bsa_pkg::S_FREE_RANGE: begin
                if (i_stat.foreign) begin
                    o_cmd.res_we   = 1'b1;
                    o_cmd.res_kind = bsa_pkg::RK_CODE;
                    o_cmd.res_code = bsa_pkg::ST_FOREIGN;
                    n_state        = bsa_pkg::S_DONE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = bsa_pkg::S_FREE_DIV;
                end
            end
            bsa_pkg::S_FREE_DIV: begin
                if (i_stat.div_done) begin
                    n_state = bsa_pkg::S_FREE_ALIGN;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            bsa_pkg::S_FREE_ALIGN: begin
                if (i_stat.misaligned) begin
                    o_cmd.res_we   = 1'b1;
                    o_cmd.res_kind = bsa_pkg::RK_CODE;
                    o_cmd.res_code = bsa_pkg::ST_MISALIGNED;
                    n_state        = bsa_pkg::S_DONE;
                end else begin
                    o_cmd.rd_issue = 1'b1;
                    o_cmd.rd_free  = 1'b1;
                    n_state        = bsa_pkg::S_FREE_CHK;
                end
            end
            bsa_pkg::S_FREE_CHK: begin
                o_cmd.res_we = 1'b1;
                if (i_stat.bit_set) begin
                    o_cmd.free_wr  = 1'b1;
                    o_cmd.res_kind = bsa_pkg::RK_FREE;
                end else begin
                    o_cmd.res_kind = bsa_pkg::RK_CODE;
                    o_cmd.res_code = bsa_pkg::ST_DOUBLE_FREE;
                end
                n_state = bsa_pkg::S_DONE;
            end
            bsa_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = bsa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bsa_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/bsa_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_dp
// Datapath of the slot allocator: configuration registers, bitmap memory
// with row valid bits, first-clear-bit picker, shared multiplier, restoring
// divider and the output register.
// ----------------------------------------------------------------------------
module bsa_dp #(
    parameter int MAX_SLOTS = bsa_pkg::MAX_SLOTS_DEF,
    parameter int MAP_ROWS  = bsa_pkg::MAP_ROWS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [bsa_pkg::S_TDATA_W-1:0]     i_in_tdata,
    input  logic [bsa_pkg::REQ_W-1:0]         i_in_tuser,
    input  logic                              i_cfg_valid,
    input  logic [bsa_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bsa_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  bsa_pkg::t_cmd                     i_cmd,
    output bsa_pkg::t_stat                    o_stat,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [bsa_pkg::M_TDATA_W-1:0]     o_out_tdata,
    output logic [bsa_pkg::STATUS_W-1:0]      o_out_tuser
);

    localparam int CAP    = (MAX_SLOTS < MAP_ROWS * bsa_pkg::WORD_BITS) ?
                            MAX_SLOTS : MAP_ROWS * bsa_pkg::WORD_BITS;
    localparam int ROW_W  = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
    localparam int GI_W   = ROW_W + bsa_pkg::BIT_W;
    localparam int CNT_W  = GI_W + 1;
    localparam int CMP_W  = (CNT_W > bsa_pkg::SIU_W) ? CNT_W : bsa_pkg::SIU_W;
    localparam int PROD_W = CNT_W + bsa_pkg::SB_W;
    localparam int WB     = bsa_pkg::WORD_BITS;

    // configuration
    logic [bsa_pkg::ADDR_W-1:0] r_base;
    logic [bsa_pkg::SB_W-1:0]   r_sb;
    logic [bsa_pkg::SIU_W-1:0]  r_siu;

    // request
    bsa_pkg::t_req              r_req;
    logic [bsa_pkg::SIZE_W-1:0] r_size;
    logic [bsa_pkg::ADDR_W-1:0] r_addr;
    logic                       r_zreq;

    // bitmap
    logic [WB-1:0]              r_mem [MAP_ROWS];
    logic [MAP_ROWS-1:0]        r_row_vld;
    logic [WB-1:0]              r_rd_data;
    logic                       r_rd_vld;
    logic [ROW_W-1:0]           r_row;

    // arithmetic
    logic [bsa_pkg::ADDR_W-1:0]    r_prod;
    logic [bsa_pkg::ADDR_W-1:0]    r_off;
    logic [GI_W-1:0]               r_idx;
    logic [bsa_pkg::ADDR_W-1:0]    r_quo;
    logic [bsa_pkg::SB_W-1:0]      r_rem;
    logic [bsa_pkg::DIV_CNT_W-1:0] r_div_cnt;

    // result and output
    bsa_pkg::t_status              r_res_status;
    logic [bsa_pkg::ADDR_W-1:0]    r_res_addr;
    logic [bsa_pkg::SIDX_W-1:0]    r_res_idx;
    logic [bsa_pkg::SB_W-1:0]      r_res_freed;
    logic                          r_res_zf;
    logic                          r_out_vld;
    bsa_pkg::t_status              r_out_status;
    logic [bsa_pkg::ADDR_W-1:0]    r_out_addr;
    logic [bsa_pkg::SIDX_W-1:0]    r_out_idx;
    logic [bsa_pkg::SB_W-1:0]      r_out_freed;
    logic                          r_out_zf;

    logic [CMP_W-1:0]              siu_ext;
    logic [CNT_W-1:0]              mgd_cnt;
    logic [WB-1:0]                 eff;
    logic [WB-1:0]                 avail;
    logic [WB-1:0]                 lowest;
    logic [bsa_pkg::BIT_W-1:0]     pick_bit;
    logic [GI_W-1:0]               pick_idx;
    logic [ROW_W-1:0]              quo_row;
    logic [bsa_pkg::BIT_W-1:0]     quo_bit;
    logic [ROW_W-1:0]              rd_addr;
    logic [ROW_W-1:0]              wr_addr;
    logic [WB-1:0]                 wr_data;
    logic [CNT_W-1:0]              mul_a;
    logic [PROD_W-1:0]             prod_c;
    logic [bsa_pkg::SB_W:0]        trial;
    logic                          resize_fit;
    logic                          is_alloc_zf;
    bsa_pkg::t_op                  stat_op;

    assign siu_ext  = CMP_W'(r_siu);
    assign mgd_cnt  = (siu_ext > CMP_W'(CAP)) ? CNT_W'(CAP) : CNT_W'(siu_ext);
    assign eff      = r_rd_vld ? r_rd_data : '0;
    assign quo_row  = r_quo[bsa_pkg::BIT_W +: ROW_W];
    assign quo_bit  = r_quo[bsa_pkg::BIT_W-1:0];

    always_comb begin
        for (int b = 0; b < WB; b++) begin
            avail[b] = !eff[b] &&
                       ({1'b0, r_row, bsa_pkg::BIT_W'(b)} < mgd_cnt);
        end
    end

    assign lowest = avail & (~avail + WB'(1));

    always_comb begin
        pick_bit = '0;
        for (int b = 0; b < WB; b++) begin
            if (lowest[b]) begin
                pick_bit = pick_bit | bsa_pkg::BIT_W'(b);
            end
        end
    end

    assign pick_idx   = {r_row, pick_bit};
    assign rd_addr    = i_cmd.rd_free ? quo_row : r_row;
    assign wr_addr    = i_cmd.free_wr ? quo_row : r_row;
    assign wr_data    = i_cmd.free_wr ? (eff & ~(WB'(1) << quo_bit)) : (eff | lowest);
    assign mul_a      = i_cmd.mul_idx ? CNT_W'(pick_idx) : mgd_cnt;
    assign prod_c     = PROD_W'(mul_a) * PROD_W'(r_sb);
    assign trial      = {r_rem, r_quo[bsa_pkg::ADDR_W-1]} - {1'b0, r_sb};
    assign resize_fit = r_size <= bsa_pkg::SIZE_W'(r_sb);
    assign is_alloc_zf = (r_req == bsa_pkg::REQ_REMAP) ? 1'b1 : r_zreq;

    always_comb begin
        unique case (r_req)
            bsa_pkg::REQ_ALLOC:  stat_op = bsa_pkg::OP_ALLOC;
            bsa_pkg::REQ_FREE:   stat_op = bsa_pkg::OP_FREE;
            bsa_pkg::REQ_RESIZE: stat_op = bsa_pkg::OP_RESIZE;
            bsa_pkg::REQ_REMAP: begin
                if (r_addr == '0) begin
                    stat_op = bsa_pkg::OP_ALLOC;
                end else if (r_size == '0) begin
                    stat_op = bsa_pkg::OP_FREE;
                end else begin
                    stat_op = bsa_pkg::OP_RESIZE;
                end
            end
            default: stat_op = bsa_pkg::OP_RESIZE;
        endcase
    end

    assign o_stat.op         = stat_op;
    assign o_stat.size_bad   = (r_size == '0) || !resize_fit;
    assign o_stat.addr_null  = r_addr == '0;
    assign o_stat.foreign    = (r_sb == '0) || (r_off >= r_prod);
    assign o_stat.hit        = |avail;
    assign o_stat.scan_last  = (r_row == ROW_W'(MAP_ROWS - 1)) ||
                               (({1'b0, r_row, bsa_pkg::BIT_W'(0)} + CNT_W'(WB)) >= mgd_cnt);
    assign o_stat.div_done   = r_div_cnt == bsa_pkg::DIV_CNT_W'(bsa_pkg::DIV_STEPS);
    assign o_stat.misaligned = r_rem != '0;
    assign o_stat.bit_set    = eff[quo_bit];
    assign o_stat.out_free   = !r_out_vld || i_out_ready;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base    <= bsa_pkg::SLOT_BASE_RST;
            r_sb      <= bsa_pkg::SLOT_BYTES_RST;
            r_siu     <= bsa_pkg::SLOTS_IN_USE_RST;
            r_row_vld <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (bsa_pkg::t_reg_idx'(i_cfg_index))
                    bsa_pkg::REG_SLOT_BASE:    r_base <= i_cfg_data;
                    bsa_pkg::REG_SLOT_BYTES:   r_sb   <= i_cfg_data[bsa_pkg::SB_W-1:0];
                    bsa_pkg::REG_SLOTS_IN_USE: r_siu  <= i_cfg_data[bsa_pkg::SIU_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.alloc_wr || i_cmd.free_wr) begin
                r_row_vld[wr_addr] <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // bitmap memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.alloc_wr || i_cmd.free_wr) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_vld  <= r_row_vld[rd_addr];
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req  <= bsa_pkg::t_req'(i_in_tuser);
            r_size <= i_in_tdata[31:0];
            r_addr <= i_in_tdata[63:32];
            r_zreq <= i_in_tdata[64];
            r_row  <= '0;
        end else if (i_cmd.word_inc) begin
            r_row <= r_row + ROW_W'(1);
        end
        if (i_cmd.mul_region) begin
            r_prod <= bsa_pkg::ADDR_W'(prod_c);
            r_off  <= r_addr - r_base;
        end else if (i_cmd.mul_idx) begin
            r_prod <= bsa_pkg::ADDR_W'(prod_c);
            r_idx  <= pick_idx;
        end
        if (i_cmd.div_start) begin
            r_quo     <= r_off;
            r_rem     <= '0;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            if (!trial[bsa_pkg::SB_W]) begin
                r_rem <= trial[bsa_pkg::SB_W-1:0];
                r_quo <= {r_quo[bsa_pkg::ADDR_W-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[bsa_pkg::SB_W-2:0], r_quo[bsa_pkg::ADDR_W-1]};
                r_quo <= {r_quo[bsa_pkg::ADDR_W-2:0], 1'b0};
            end
            r_div_cnt <= r_div_cnt + bsa_pkg::DIV_CNT_W'(1);
        end
        if (i_cmd.res_we) begin
            r_res_status <= bsa_pkg::ST_OK;
            r_res_addr   <= '0;
            r_res_idx    <= '0;
            r_res_freed  <= '0;
            r_res_zf     <= 1'b0;
            case (i_cmd.res_kind)
                bsa_pkg::RK_CODE: begin
                    r_res_status <= i_cmd.res_code;
                end
                bsa_pkg::RK_RESIZE: begin
                    if (resize_fit) begin
                        r_res_addr <= r_addr;
                    end else begin
                        r_res_status <= bsa_pkg::ST_BAD_SIZE;
                    end
                end
                bsa_pkg::RK_ALLOC: begin
                    r_res_addr <= r_base + r_prod;
                    r_res_idx  <= bsa_pkg::SIDX_W'(r_idx);
                    r_res_zf   <= is_alloc_zf;
                end
                bsa_pkg::RK_FREE: begin
                    r_res_idx   <= r_quo[bsa_pkg::SIDX_W-1:0];
                    r_res_freed <= r_sb;
                end
                default: ;
            endcase
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_addr   <= r_res_addr;
            r_out_idx    <= r_res_idx;
            r_out_freed  <= r_res_freed;
            r_out_zf     <= r_res_zf;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_tuser = r_out_status;
    assign o_out_tdata = {6'b0, r_out_zf, r_out_freed, r_out_idx, r_out_addr};

`ifndef SYNTHESIS
    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_vld || i_out_ready))
        else $error("result overwrites a pending output transaction");
    a_alloc_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.alloc_wr |-> o_stat.hit)
        else $error("bitmap set without a clear managed bit");
    a_alloc_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.alloc_wr |=> ({1'b0, r_idx} < mgd_cnt))
        else $error("allocated slot beyond managed count");
    a_free_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.free_wr |-> (o_stat.bit_set && r_rem == '0))
        else $error("bitmap cleared on a rejected free");
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_div_cnt < bsa_pkg::DIV_CNT_W'(bsa_pkg::DIV_STEPS)))
        else $error("divider stepped past its length");
`endif

endmodule

// ===== rtl/bitmap_slot_allocator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_slot_allocator_top
// Resize answers from decode; allocate scans the bitmap one word at a time;
// free checks the range, then runs a 32-step divider for the slot index.
// One request at a time; the next is accepted only once the result has
// entered the output register. Synchronous active-low reset clears the bitmap
// row valid bits and loads register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator_top #(
    parameter int MAX_SLOTS = bsa_pkg::MAX_SLOTS_DEF,
    parameter int MAP_ROWS  = bsa_pkg::MAP_ROWS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // size_bytes[31:0], addr[63:32], zero_request[64], zero pad [71:65]
    input  logic [bsa_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // req_type[1:0]
    input  logic [bsa_pkg::REQ_W-1:0]      s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // result_addr[31:0], slot_index[39:32], freed_bytes[56:40], zero_fill[57],
    // zero pad [63:58]
    output logic [bsa_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // status[2:0]
    output logic [bsa_pkg::STATUS_W-1:0]   m_axis_tuser,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bsa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bsa_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    bsa_pkg::t_cmd  cmd;
    bsa_pkg::t_stat stat;

    assign o_cfg_ready = 1'b1;

    bsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bsa_dp #(
        .MAX_SLOTS (MAX_SLOTS),
        .MAP_ROWS  (MAP_ROWS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_tdata  (s_axis_tdata),
        .i_in_tuser  (s_axis_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_tdata (m_axis_tdata),
        .o_out_tuser (m_axis_tuser)
    );

endmodule

// ===== tb/sv/tb_bitmap_slot_allocator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_slot_allocator_top
// Self-checking bench for the bitmap slot allocator. A scoreboard keeps its
// own slot bitmap and register copies, predicts the outcome of every accepted
// request and checks each returned transaction field by field. A directed
// burst is followed by randomized phases over several register settings and
// handshake idling profiles, including a long output hold-off.
// ----------------------------------------------------------------------------
module tb_bitmap_slot_allocator_top;

    localparam int BITMAP_BITS = bsa_pkg::MAP_ROWS_DEF * bsa_pkg::WORD_BITS;
    localparam int STALL_LIMIT = 4000;

    typedef struct {
        bsa_pkg::t_req kind;
        logic [31:0]   size;
        logic [31:0]   addr;
        logic          zero_req;
    } t_request;

    typedef struct {
        bsa_pkg::t_status status;
        logic [31:0]      addr;
        logic [7:0]       slot_idx;
        logic [16:0]      freed;
        logic             zero_fill;
    } t_outcome;

    class alloc_scoreboard;
        bit [BITMAP_BITS-1:0] in_use;
        bit [31:0]            base_addr;
        bit [16:0]            blk_bytes;
        bit [8:0]             blk_total;
        t_outcome             outcome_q[$];
        int                   errors;

        function new();
            in_use    = '0;
            base_addr = bsa_pkg::SLOT_BASE_RST;
            blk_bytes = bsa_pkg::SLOT_BYTES_RST;
            blk_total = bsa_pkg::SLOTS_IN_USE_RST;
            errors    = 0;
        endfunction

        function void write_reg(bsa_pkg::t_reg_idx idx, logic [31:0] data);
            case (idx)
                bsa_pkg::REG_SLOT_BASE:    base_addr = data;
                bsa_pkg::REG_SLOT_BYTES:   blk_bytes = data[16:0];
                bsa_pkg::REG_SLOTS_IN_USE: blk_total = data[8:0];
                default: ;
            endcase
        endfunction

        function int unsigned managed();
            int unsigned n;
            n = blk_total;
            if (n > bsa_pkg::MAX_SLOTS_DEF) n = bsa_pkg::MAX_SLOTS_DEF;
            if (n > BITMAP_BITS) n = BITMAP_BITS;
            return n;
        endfunction

        function t_outcome blank(bsa_pkg::t_status st);
            t_outcome o;
            o.status    = st;
            o.addr      = '0;
            o.slot_idx  = '0;
            o.freed     = '0;
            o.zero_fill = 1'b0;
            return o;
        endfunction

        function t_outcome take_slot(logic [31:0] sz, logic zf);
            t_outcome o;
            int unsigned n;
            n = managed();
            if (sz == 0 || sz > blk_bytes) return blank(bsa_pkg::ST_BAD_SIZE);
            for (int unsigned i = 0; i < n; i++) begin
                if (!in_use[i]) begin
                    in_use[i]   = 1'b1;
                    o           = blank(bsa_pkg::ST_OK);
                    o.addr      = base_addr + 32'(i * blk_bytes);
                    o.slot_idx  = i[7:0];
                    o.zero_fill = zf;
                    return o;
                end
            end
            return blank(bsa_pkg::ST_FULL);
        endfunction

        function t_outcome free_slot(logic [31:0] a);
            t_outcome o;
            logic [31:0] off;
            int unsigned region;
            int unsigned idx;
            if (a == 0) return blank(bsa_pkg::ST_OK);
            off    = a - base_addr;
            region = managed() * blk_bytes;
            if (blk_bytes == 0 || off >= region) return blank(bsa_pkg::ST_FOREIGN);
            if (off % blk_bytes != 0) return blank(bsa_pkg::ST_MISALIGNED);
            idx = off / blk_bytes;
            if (!in_use[idx]) return blank(bsa_pkg::ST_DOUBLE_FREE);
            in_use[idx] = 1'b0;
            o           = blank(bsa_pkg::ST_OK);
            o.slot_idx  = idx[7:0];
            o.freed     = blk_bytes;
            return o;
        endfunction

        function t_outcome resize_slot(logic [31:0] a, logic [31:0] sz);
            t_outcome o;
            if (sz > blk_bytes) return blank(bsa_pkg::ST_BAD_SIZE);
            o      = blank(bsa_pkg::ST_OK);
            o.addr = a;
            return o;
        endfunction

        function void note_request(t_request r);
            t_outcome o;
            case (r.kind)
                bsa_pkg::REQ_ALLOC:  o = take_slot(r.size, r.zero_req);
                bsa_pkg::REQ_FREE:   o = free_slot(r.addr);
                bsa_pkg::REQ_RESIZE: o = resize_slot(r.addr, r.size);
                default: begin
                    if (r.addr == 0) begin
                        o = take_slot(r.size, 1'b1);
                    end else if (r.size == 0) begin
                        o      = free_slot(r.addr);
                        o.addr = '0;
                    end else begin
                        o = resize_slot(r.addr, r.size);
                    end
                end
            endcase
            outcome_q.push_back(o);
        endfunction

        function void compare(string name, longint unsigned exp, longint unsigned act);
            if (exp != act) begin
                $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp, act);
                errors++;
            end
        endfunction

        function void check_result(t_outcome got);
            t_outcome exp;
            if (outcome_q.size() == 0) begin
                $error("unexpected result transaction: status %0d addr 0x%0h",
                       got.status, got.addr);
                errors++;
                return;
            end
            exp = outcome_q.pop_front();
            compare("status", exp.status, got.status);
            compare("result_addr", exp.addr, got.addr);
            compare("slot_index", exp.slot_idx, got.slot_idx);
            compare("freed_bytes", exp.freed, got.freed);
            compare("zero_fill", exp.zero_fill, got.zero_fill);
        endfunction

        function int pending();
            return outcome_q.size();
        endfunction
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [bsa_pkg::S_TDATA_W-1:0]  s_axis_tdata;
    logic [bsa_pkg::REQ_W-1:0]      s_axis_tuser;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [bsa_pkg::M_TDATA_W-1:0]  m_axis_tdata;
    logic [bsa_pkg::STATUS_W-1:0]   m_axis_tuser;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [bsa_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [bsa_pkg::CFG_DATA_W-1:0] i_cfg_data;

    alloc_scoreboard sb;
    int src_idle;
    int snk_stall;
    int hold_off_cycles;
    int quiet_cycles;

    bitmap_slot_allocator_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // output side: stall at random, or hold off for a counted stretch
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_cycles > 0) begin
                m_axis_tready = 1'b0;
                hold_off_cycles--;
            end else begin
                m_axis_tready = ($urandom_range(0, 99) >= snk_stall);
            end
        end
    end

    always @(posedge i_clk) begin
        t_outcome got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status    = bsa_pkg::t_status'(m_axis_tuser);
            got.addr      = m_axis_tdata[31:0];
            got.slot_idx  = m_axis_tdata[39:32];
            got.freed     = m_axis_tdata[56:40];
            got.zero_fill = m_axis_tdata[57];
            sb.check_result(got);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_request make_request(bsa_pkg::t_req kind, logic [31:0] size,
                                              logic [31:0] addr, logic zero_req);
        t_request r;
        r.kind     = kind;
        r.size     = size;
        r.addr     = addr;
        r.zero_req = zero_req;
        return r;
    endfunction

    function automatic logic [31:0] slot_addr(int unsigned idx);
        return sb.base_addr + 32'(idx * sb.blk_bytes);
    endfunction

    function automatic logic [31:0] pick_size();
        int unsigned k;
        k = $urandom_range(0, 99);
        if (k < 70) return (sb.blk_bytes == 0) ? $urandom_range(1, 8) :
                                                 $urandom_range(1, sb.blk_bytes);
        if (k < 78) return 32'd0;
        if (k < 84) return sb.blk_bytes;
        if (k < 91) return sb.blk_bytes + 1;
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_addr();
        int unsigned k;
        int unsigned n;
        int unsigned idx;
        n   = sb.managed();
        idx = (n == 0) ? 0 : $urandom_range(0, n - 1);
        k   = $urandom_range(0, 99);
        if (k < 65) return slot_addr(idx);
        if (k < 75) return slot_addr(idx) +
                           ((sb.blk_bytes > 1) ? $urandom_range(1, sb.blk_bytes - 1) : 1);
        if (k < 83) return slot_addr(n + $urandom_range(0, 3));
        if (k < 88) return 32'd0;
        return $urandom;
    endfunction

    function automatic t_request random_request(int alloc_pct);
        t_request r;
        int unsigned pick;
        r    = make_request(bsa_pkg::REQ_FREE, $urandom, pick_addr(),
                            1'($urandom_range(0, 1)));
        pick = $urandom_range(0, 99);
        if (pick < alloc_pct) begin
            r.kind = bsa_pkg::REQ_ALLOC;
            r.size = pick_size();
        end else if (pick < alloc_pct + 10) begin
            r.kind = bsa_pkg::REQ_RESIZE;
            r.size = pick_size();
        end else if (pick < alloc_pct + 25) begin
            r.kind = bsa_pkg::REQ_REMAP;
            case ($urandom_range(0, 2))
                0: begin
                    r.addr = '0;
                    r.size = pick_size();
                end
                1: r.size = '0;
                default: r.size = pick_size();
            endcase
        end
        return r;
    endfunction

    task automatic send_request(t_request r);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_idle) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {{(bsa_pkg::S_TDATA_W-65){1'b0}}, r.zero_req, r.addr, r.size};
        s_axis_tuser  = r.kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_request(r);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(bsa_pkg::t_reg_idx idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic run_phase(logic [31:0] base, logic [31:0] size_data,
                             logic [31:0] count_data, int src, int snk,
                             int items, int alloc_pct, int hold);
        wait_idle();
        write_cfg(bsa_pkg::REG_SLOT_BASE, base);
        write_cfg(bsa_pkg::REG_SLOT_BYTES, size_data);
        write_cfg(bsa_pkg::REG_SLOTS_IN_USE, count_data);
        @(negedge i_clk);
        i_cfg_valid     = 1'b0;
        src_idle        = src;
        snk_stall       = snk;
        hold_off_cycles = hold;
        repeat (items) send_request(random_request(alloc_pct));
    endtask

    initial begin
        sb              = new();
        src_idle        = 0;
        snk_stall       = 0;
        hold_off_cycles = 0;
        quiet_cycles    = 0;
        i_rst_n         = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tuser    = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed burst on the reset register values
        send_request(make_request(bsa_pkg::REQ_ALLOC, 32'd0, 32'd0, 1'b0));
        send_request(make_request(bsa_pkg::REQ_ALLOC, 32'd65, 32'd0, 1'b1));
        send_request(make_request(bsa_pkg::REQ_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
        send_request(make_request(bsa_pkg::REQ_ALLOC, 32'd64, 32'd0, 1'b1));
        send_request(make_request(bsa_pkg::REQ_ALLOC, 32'd1, 32'h1234, 1'b0));
        send_request(make_request(bsa_pkg::REQ_FREE, 32'd0, 32'd0, 1'b1));
        send_request(make_request(bsa_pkg::REQ_FREE, 32'd0, 32'd4160, 1'b0));
        send_request(make_request(bsa_pkg::REQ_FREE, 32'hFFFF_FFFF, 32'd4160, 1'b0));
        send_request(make_request(bsa_pkg::REQ_FREE, 32'd0, 32'd4097, 1'b0));
        send_request(make_request(bsa_pkg::REQ_FREE, 32'd0, 32'd4095, 1'b0));
        send_request(make_request(bsa_pkg::REQ_FREE, 32'd0, 32'd4096 + 32'd16384, 1'b0));
        send_request(make_request(bsa_pkg::REQ_FREE, 32'd0, 32'hFFFF_FFFF, 1'b1));
        send_request(make_request(bsa_pkg::REQ_RESIZE, 32'd64, 32'hFFFF_FFFF, 1'b1));
        send_request(make_request(bsa_pkg::REQ_RESIZE, 32'd65, 32'h1234, 1'b0));
        send_request(make_request(bsa_pkg::REQ_RESIZE, 32'd0, 32'd0, 1'b0));
        send_request(make_request(bsa_pkg::REQ_REMAP, 32'd10, 32'd0, 1'b0));
        send_request(make_request(bsa_pkg::REQ_REMAP, 32'd0, 32'd4096, 1'b0));
        send_request(make_request(bsa_pkg::REQ_REMAP, 32'd0, 32'd4096, 1'b0));
        send_request(make_request(bsa_pkg::REQ_REMAP, 32'd64, 32'h5000, 1'b0));
        send_request(make_request(bsa_pkg::REQ_REMAP, 32'd65, 32'h5000, 1'b1));
        send_request(make_request(bsa_pkg::REQ_REMAP, 32'd0, 32'd0, 1'b1));
        send_request(make_request(bsa_pkg::REQ_REMAP, 32'd0, 32'd4097, 1'b0));
        repeat (120) send_request(random_request(35));

        // fill, shrink the count, then grow it back
        run_phase(32'd4096, 32'd64, 32'd256, 50, 0, 200, 60, 0);
        run_phase(32'd4096, 32'd64, 32'd6, 0, 50, 150, 35, 0);
        run_phase(32'd4096, 32'd64, 32'd256, 12, 12, 150, 25, 0);
        // slot addresses wrap through zero
        run_phase(32'hFFFF_0000, 32'd4096, 32'd32, 0, 0, 200, 40, 0);
        run_phase(32'd1, 32'd1, 32'd1, 50, 0, 80, 35, 0);
        run_phase($urandom, 32'd0, 32'd0, 0, 50, 60, 35, 0);
        run_phase(32'hFFFF_FFFF, 32'd65536, 32'd256, 12, 12, 200, 40, 0);
        run_phase($urandom, 32'hFFFF_FFFF, 32'hABCD_E1FF, 0, 0, 200, 40, 0);
        run_phase(32'd0,
                  {15'($urandom_range(0, 32767)), 17'(0)} | 32'($urandom_range(1, 300)),
                  {23'($urandom_range(0, 8388607)), 9'(0)} | 32'($urandom_range(1, 300)),
                  50, 0, 200, 35, 0);
        // long output hold-off while requests keep coming
        run_phase(32'd4096, 32'd64, 32'd256, 0, 50, 150, 30, 400);

        wait_idle();
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/bsa_pkg.sv
rtl/bsa_ctrl.sv
rtl/bsa_dp.sv
rtl/bitmap_slot_allocator_top.sv
tb/sv/tb_bitmap_slot_allocator_top.sv
